[design/iirdz_pkg.sv]
// Shared types, widths and constants of the dead-zone IIR filter.
package iirdz_pkg;

   localparam int SAMPLE_WIDTH    = 32;
   localparam int COEF_WIDTH      = 32;
   localparam int DZ_WIDTH        = 31;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int DIGIT_WIDTH     = 8;
   localparam int NUM_DIGITS      = SAMPLE_WIDTH / DIGIT_WIDTH;
   localparam int NUM_FF_TAPS     = 3;
   localparam int NUM_FB_TAPS     = 2;
   localparam int NUM_TERMS       = NUM_FF_TAPS + NUM_FB_TAPS;
   localparam int ACC_WIDTH       = 66;
   localparam int DIV_STEPS       = ACC_WIDTH / 2;
   localparam int PART_WIDTH      = COEF_WIDTH + DIGIT_WIDTH + 1;

   localparam logic [COEF_WIDTH-1:0] EPS_Q28      = COEF_WIDTH'(268);
   localparam logic [COEF_WIDTH-1:0] A0_RESET     = COEF_WIDTH'(32'h1000_0000);
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NUM_COEF_0 = 3'd0,
      CSR_NUM_COEF_1 = 3'd1,
      CSR_NUM_COEF_2 = 3'd2,
      CSR_DEN_COEF_0 = 3'd3,
      CSR_DEN_COEF_1 = 3'd4,
      CSR_DEN_COEF_2 = 3'd5,
      CSR_DEAD_ZONE  = 3'd6
   } csr_index_type;

   localparam logic REQ_FILTER = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

endpackage

[design/iirdz_channels.sv]
// Valid/ready channel interfaces of the dead-zone IIR filter.
interface iirdz_req_if import iirdz_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       req_type;
   sample_type sample_in;
   modport source (output valid, req_type, sample_in, input ready);
   modport sink   (input valid, req_type, sample_in, output ready);
endinterface

interface iirdz_rsp_if import iirdz_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type filtered_out;
   logic       held;
   modport source (output valid, filtered_out, held, input ready);
   modport sink   (input valid, filtered_out, held, output ready);
endinterface

interface iirdz_csr_if import iirdz_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [COEF_WIDTH-1:0]      data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/iir_filter_with_output_dead_zone.sv]
// Second-order direct form I IIR filter with an output dead zone, digit-serial datapath.
//
// The request channel carries one transaction per sample: a filter request pushes
// sample_in into the input history and produces exactly one response; a clear request
// zeroes both histories, keeps the last emitted value and produces no response.
// The configuration channel is always ready and writes coefficient registers b0..b2,
// a0..a2 and the dead zone by index; the user must write it only while the filter is idle,
// as the block does not enforce this. A filter transaction forms five products at four
// 8-bit digits each, takes magnitudes, runs a two-bit-per-cycle restoring divider by a0,
// and applies saturation and the dead zone. The next request is accepted in the cycle
// after the response is loaded, so the filter takes no new sample before the previous
// one is through.
// The response sits in an output register: a stalled receiver does not block the next
// request, which is only held in its final cycle until the previous response is taken.
// Reset is synchronous; it restores the coefficient defaults (a0 = 1.0), clears the
// histories and the last emitted value, and empties the output register.
module iir_filter_with_output_dead_zone import iirdz_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   iirdz_req_if.sink   req_ch,
   iirdz_rsp_if.source rsp_ch,
   iirdz_csr_if.sink   csr_ch
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MAC   = 5'b00010,
      S_SETUP = 5'b00100,
      S_DIV   = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   coef_type               b_ff [NUM_FF_TAPS];
   coef_type               a0_ff;
   coef_type               a_ff [NUM_FB_TAPS];
   logic [DZ_WIDTH-1:0]    dz_ff;
   sample_type             x_ff [NUM_FF_TAPS];
   sample_type             y_ff [NUM_FB_TAPS];
   sample_type             last_ff;

   logic [2:0]                        term_ff;
   logic [1:0]                        digit_ff;
   logic [SAMPLE_WIDTH-DIGIT_WIDTH-1:0] mul_sr_ff, mul_sr_in;
   acc_type                           acc_ff, acc_in;

   logic [ACC_WIDTH-1:0]    div_sr_ff, div_sr_in;
   logic [COEF_WIDTH-1:0]   rem_ff, rem_in;
   logic [SAMPLE_WIDTH:0]   quo_ff, quo_in;
   logic                    quo_ovf_ff, quo_ovf_in;
   logic [COEF_WIDTH-1:0]   dvs_ff;
   logic                    neg_ff, small_ff;
   logic [5:0]              div_cnt_ff;

   logic       rsp_valid_ff;
   sample_type rsp_data_ff;
   logic       rsp_held_ff;

   coef_type                coef_sel;
   sample_type              hist_sel;
   logic [DIGIT_WIDTH-1:0]  digit;
   logic signed [DIGIT_WIDTH:0] digit_s;
   logic signed [PART_WIDTH-1:0] partial;
   acc_type                 shifted;

   acc_type                 acc_mag;
   logic [COEF_WIDTH-1:0]   a0_mag;

   sample_type              y_new;
   logic signed [SAMPLE_WIDTH:0] diff;
   logic [SAMPLE_WIDTH:0]   diff_mag;
   logic                    held_new;

   logic req_fire, done_go;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.filtered_out = rsp_data_ff;
   assign rsp_ch.held = rsp_held_ff;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign done_go  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Multiply-accumulate: one 8-bit digit of the history operand per cycle.
   always_comb begin
      case (term_ff)
         3'd0:    begin coef_sel = b_ff[0]; hist_sel = x_ff[0]; end
         3'd1:    begin coef_sel = b_ff[1]; hist_sel = x_ff[1]; end
         3'd2:    begin coef_sel = b_ff[2]; hist_sel = x_ff[2]; end
         3'd3:    begin coef_sel = a_ff[0]; hist_sel = y_ff[0]; end
         3'd4:    begin coef_sel = a_ff[1]; hist_sel = y_ff[1]; end
         default: begin coef_sel = '0;      hist_sel = '0;      end
      endcase
      if (digit_ff == 2'd0) begin
         digit     = hist_sel[DIGIT_WIDTH-1:0];
         mul_sr_in = hist_sel[SAMPLE_WIDTH-1:DIGIT_WIDTH];
      end else begin
         digit     = mul_sr_ff[DIGIT_WIDTH-1:0];
         mul_sr_in = mul_sr_ff >> DIGIT_WIDTH;
      end
      if (digit_ff == 2'(NUM_DIGITS-1)) begin
         digit_s = {digit[DIGIT_WIDTH-1], digit};
      end else begin
         digit_s = {1'b0, digit};
      end
      partial = coef_sel * digit_s;
      shifted = ACC_WIDTH'(partial) <<< {digit_ff, 3'b000};
      if (term_ff >= 3'(NUM_FF_TAPS)) begin
         acc_in = acc_ff - shifted;
      end else begin
         acc_in = acc_ff + shifted;
      end
   end

   assign acc_mag = acc_ff[ACC_WIDTH-1] ? -acc_ff : acc_ff;
   assign a0_mag  = a0_ff[COEF_WIDTH-1] ? COEF_WIDTH'(-a0_ff) : a0_ff;

   // Restoring division, two quotient bits per cycle.
   always_comb begin
      logic [COEF_WIDTH:0] trial;
      logic                ge;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      quo_ovf_in = quo_ovf_ff;
      div_sr_in  = div_sr_ff;
      for (int k = 0; k < 2; k++) begin
         trial     = {rem_in, div_sr_in[ACC_WIDTH-1]};
         div_sr_in = div_sr_in << 1;
         ge        = (trial >= {1'b0, dvs_ff});
         if (ge) begin
            trial = trial - {1'b0, dvs_ff};
         end
         rem_in     = trial[COEF_WIDTH-1:0];
         quo_ovf_in = quo_ovf_in | quo_in[SAMPLE_WIDTH];
         quo_in     = {quo_in[SAMPLE_WIDTH-1:0], ge};
      end
   end

   // Saturation and dead zone.
   always_comb begin
      if (small_ff) begin
         y_new = '0;
      end else if (neg_ff) begin
         if (quo_ovf_ff || quo_ff > {1'b1, {SAMPLE_WIDTH{1'b0}}} >> 1) begin
            y_new = SAT_MIN;
         end else begin
            y_new = SAMPLE_WIDTH'(-quo_ff);
         end
      end else begin
         if (quo_ovf_ff || quo_ff > {1'b0, SAT_MAX}) begin
            y_new = SAT_MAX;
         end else begin
            y_new = quo_ff[SAMPLE_WIDTH-1:0];
         end
      end
      diff     = {y_new[SAMPLE_WIDTH-1], y_new} - {last_ff[SAMPLE_WIDTH-1], last_ff};
      diff_mag = diff[SAMPLE_WIDTH] ? (SAMPLE_WIDTH+1)'(-diff) : diff;
      held_new = (diff_mag < (SAMPLE_WIDTH+1)'(dz_ff));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_ch.req_type == REQ_FILTER) begin
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            if (digit_ff == 2'(NUM_DIGITS-1) && term_ff == 3'(NUM_TERMS-1)) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: state_in = S_DIV;
         S_DIV: begin
            if (div_cnt_ff == 6'(DIV_STEPS-1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (done_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         b_ff         <= '{default: '0};
         a0_ff        <= A0_RESET;
         a_ff         <= '{default: '0};
         dz_ff        <= '0;
         x_ff         <= '{default: '0};
         y_ff         <= '{default: '0};
         last_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_ch.ready && !done_go) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               CSR_NUM_COEF_0: b_ff[0] <= csr_ch.data;
               CSR_NUM_COEF_1: b_ff[1] <= csr_ch.data;
               CSR_NUM_COEF_2: b_ff[2] <= csr_ch.data;
               CSR_DEN_COEF_0: a0_ff   <= csr_ch.data;
               CSR_DEN_COEF_1: a_ff[0] <= csr_ch.data;
               CSR_DEN_COEF_2: a_ff[1] <= csr_ch.data;
               CSR_DEAD_ZONE:  dz_ff   <= csr_ch.data[DZ_WIDTH-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            if (req_ch.req_type == REQ_CLEAR) begin
               x_ff <= '{default: '0};
               y_ff <= '{default: '0};
            end else begin
               x_ff[2] <= x_ff[1];
               x_ff[1] <= x_ff[0];
               x_ff[0] <= req_ch.sample_in;
            end
         end
         if (done_go) begin
            y_ff[1]      <= y_ff[0];
            y_ff[0]      <= y_new;
            rsp_valid_ff <= 1'b1;
            if (!held_new) begin
               last_ff <= y_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            term_ff  <= '0;
            digit_ff <= '0;
            acc_ff   <= '0;
         end
         S_MAC: begin
            acc_ff    <= acc_in;
            mul_sr_ff <= mul_sr_in;
            digit_ff  <= digit_ff + 2'd1;
            if (digit_ff == 2'(NUM_DIGITS-1)) begin
               term_ff <= term_ff + 3'd1;
            end
         end
         S_SETUP: begin
            div_sr_ff  <= acc_mag;
            dvs_ff     <= a0_mag;
            small_ff   <= (a0_mag <= EPS_Q28);
            neg_ff     <= acc_ff[ACC_WIDTH-1] ^ a0_ff[COEF_WIDTH-1];
            rem_ff     <= '0;
            quo_ff     <= '0;
            quo_ovf_ff <= 1'b0;
            div_cnt_ff <= '0;
         end
         S_DIV: begin
            div_sr_ff  <= div_sr_in;
            rem_ff     <= rem_in;
            quo_ff     <= quo_in;
            quo_ovf_ff <= quo_ovf_in;
            div_cnt_ff <= div_cnt_ff + 6'd1;
         end
         S_DONE: begin
            if (done_go) begin
               rsp_data_ff <= held_new ? last_ff : y_new;
               rsp_held_ff <= held_new;
            end
         end
         default: ;
      endcase
   end

endmodule
